// File: rtl/core/nearest_square_sqrt_estimate_macros.svh
// Assertion macros for the nearest-square square-root estimate checker.
`ifndef NEAREST_SQUARE_SQRT_ESTIMATE_MACROS_SVH
`define NEAREST_SQUARE_SQRT_ESTIMATE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define NSSE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define NSSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/nsse_pkg.sv
// Package: types, constants and microcode program of the square-root estimator.
`default_nettype none
package nsse_pkg;

   // Default configuration
   localparam int IN_WIDTH_DEF  = 31;
   localparam int FRAC_BITS_DEF = 16;

   // Width of the scratch word used for output saturation
   localparam int WIDE_W = 80;

   // Output field widths
   localparam int ROOT_W = 16;
   localparam int EST_W  = 32;

   // Microcode program counter
   localparam int PC_W = 3;
   typedef logic [PC_W-1:0] pc_type;

   localparam pc_type PC_IDLE   = 3'd0;
   localparam pc_type PC_SQRT   = 3'd1;
   localparam pc_type PC_PICK   = 3'd2;
   localparam pc_type PC_DIV    = 3'd3;
   localparam pc_type PC_FINISH = 3'd4;

   // Datapath operation selected by a control word
   typedef enum logic [2:0] {
      OP_LOAD,
      OP_SQRT,
      OP_PICK,
      OP_DIV,
      OP_FINISH
   } op_type;

   // Branch condition of a control word
   typedef enum logic [2:0] {
      C_NEXT,
      C_WAIT,
      C_LOOP,
      C_SQUARE,
      C_JUMP
   } cond_type;

   // Step counter action
   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_SQRT,
      CNT_DIV,
      CNT_DEC
   } cnt_sel_type;

   typedef struct packed {
      op_type      op;
      cond_type    cond;
      cnt_sel_type cnt_sel;
      pc_type      target;
   } ctrl_word_type;

   // Control from the sequencer to the datapath
   typedef struct packed {
      op_type op;
      logic   accept;
   } dp_ctrl_type;

   // Status from the datapath to the sequencer
   typedef struct packed {
      logic is_square;
   } dp_status_type;

   // Microcode ROM
   function automatic ctrl_word_type ucode_word(input pc_type pc);
      ctrl_word_type w;
      case (pc)
         PC_IDLE:   w = '{op: OP_LOAD,   cond: C_WAIT,   cnt_sel: CNT_SQRT, target: PC_IDLE};
         PC_SQRT:   w = '{op: OP_SQRT,   cond: C_LOOP,   cnt_sel: CNT_DEC,  target: PC_SQRT};
         PC_PICK:   w = '{op: OP_PICK,   cond: C_SQUARE, cnt_sel: CNT_DIV,  target: PC_FINISH};
         PC_DIV:    w = '{op: OP_DIV,    cond: C_LOOP,   cnt_sel: CNT_DEC,  target: PC_DIV};
         PC_FINISH: w = '{op: OP_FINISH, cond: C_JUMP,   cnt_sel: CNT_HOLD, target: PC_IDLE};
         default:   w = '{op: OP_FINISH, cond: C_JUMP,   cnt_sel: CNT_HOLD, target: PC_IDLE};
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/nsse_sequencer.sv
// Microcode sequencer: program counter, step counter and branch logic.
`default_nettype none
module nsse_sequencer #(
   parameter int IN_WIDTH  = nsse_pkg::IN_WIDTH_DEF,
   parameter int FRAC_BITS = nsse_pkg::FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire nsse_pkg::dp_status_type status,
   output nsse_pkg::dp_ctrl_type       ctrl,
   output logic                       busy
);

   localparam int RW = (IN_WIDTH + 1) / 2;
   localparam int DW = IN_WIDTH + 2 + FRAC_BITS;
   localparam int CW = $clog2(DW);

   nsse_pkg::pc_type        pc_ff, pc_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   nsse_pkg::ctrl_word_type word;
   logic                    taken;

   // Fetch the current control word
   assign word = nsse_pkg::ucode_word(pc_ff);

   // Evaluate the branch condition
   always_comb begin
      case (word.cond)
         nsse_pkg::C_NEXT:   taken = 1'b0;
         nsse_pkg::C_WAIT:   taken = !start;
         nsse_pkg::C_LOOP:   taken = (cnt_ff != '0);
         nsse_pkg::C_SQUARE: taken = status.is_square;
         nsse_pkg::C_JUMP:   taken = 1'b1;
         default:            taken = 1'b0;
      endcase
   end

   // Advance or jump
   assign pc_in = taken ? word.target : pc_ff + nsse_pkg::pc_type'(1);

   // Load or count down the step counter
   always_comb begin
      case (word.cnt_sel)
         nsse_pkg::CNT_HOLD: cnt_in = cnt_ff;
         nsse_pkg::CNT_SQRT: cnt_in = CW'(RW - 1);
         nsse_pkg::CNT_DIV:  cnt_in = CW'(DW - 1);
         nsse_pkg::CNT_DEC:  cnt_in = (cnt_ff != '0) ? cnt_ff - CW'(1) : cnt_ff;
         default:            cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= nsse_pkg::PC_IDLE;
         cnt_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         cnt_ff <= cnt_in;
      end
   end

   // Drive datapath control and the handshake
   assign busy        = (word.op != nsse_pkg::OP_LOAD);
   assign ctrl.op     = word.op;
   assign ctrl.accept = (word.op == nsse_pkg::OP_LOAD) && start;

endmodule
`default_nettype wire

// File: rtl/core/nsse_datapath.sv
// Datapath: bit-pair square root, nearest-square pick, restoring division, output registers.
`default_nettype none
module nsse_datapath #(
   parameter int IN_WIDTH  = nsse_pkg::IN_WIDTH_DEF,
   parameter int FRAC_BITS = nsse_pkg::FRAC_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire nsse_pkg::dp_ctrl_type        ctrl,
   input  wire logic [IN_WIDTH-1:0]         value,
   output nsse_pkg::dp_status_type          status,
   output logic                             rsp_strobe,
   output logic                             rsp_is_square,
   output logic [nsse_pkg::ROOT_W-1:0]      rsp_near_root,
   output logic [nsse_pkg::EST_W-1:0]       rsp_estimate_q16
);

   localparam int RW   = (IN_WIDTH + 1) / 2;
   localparam int RADW = 2 * RW;
   localparam int NW   = IN_WIDTH + 2;
   localparam int DENW = RW + 2;
   localparam int DW   = NW + FRAC_BITS;
   localparam int WW   = nsse_pkg::WIDE_W;
   localparam int OW_R = nsse_pkg::ROOT_W;
   localparam int OW_E = nsse_pkg::EST_W;

   // Working registers
   logic [IN_WIDTH-1:0] n_ff,    n_in;
   logic [RADW-1:0]     rad_ff,  rad_in;
   logic [RW-1:0]       root_ff, root_in;
   logic [RW:0]         rem_ff,  rem_in;
   logic [RW:0]         rsel_ff, rsel_in;
   logic                sq_ff,   sq_in;
   logic [DW-1:0]       dq_ff,   dq_in;
   logic [DENW-1:0]     drem_ff, drem_in;

   // Output registers
   logic                strobe_ff, strobe_in;
   logic                osq_ff,    osq_in;
   logic [OW_R-1:0]     oroot_ff,  oroot_in;
   logic [OW_E-1:0]     oest_ff,   oest_in;

   // Square root step signals
   logic [RW+2:0] trial;
   logic [RW+2:0] subtr;
   logic [RW+2:0] sdiff;
   logic          sge;

   // Nearest-square pick signals
   logic [RW:0]   two_r1;
   logic          go_up;
   logic [NW-1:0] n2;
   logic [NW-1:0] num;

   // Division step signals
   logic [DENW-1:0] den;
   logic [DENW:0]   dsh;
   logic [DENW:0]   ddiff;
   logic            dge;

   // Saturation signals
   logic [WW-1:0] est_full;
   logic [WW-1:0] root_full;

   // One bit-pair of the root
   assign trial = {rem_ff, rad_ff[RADW-1 -: 2]};
   assign subtr = {1'b0, root_ff, 2'b01};
   assign sge   = (trial >= subtr);
   assign sdiff = trial - subtr;

   // Pick the nearer square; a tie goes to the upper one
   assign two_r1 = {root_ff, 1'b1};
   assign go_up  = ({1'b0, two_r1} <= {rem_ff, 1'b0});
   assign n2     = {1'b0, n_ff, 1'b0};
   assign num    = go_up ? n2 + NW'(two_r1) - NW'(rem_ff) : n2 - NW'(rem_ff);

   // One quotient bit
   assign den   = {rsel_ff, 1'b0};
   assign dsh   = {drem_ff, dq_ff[DW-1]};
   assign dge   = (dsh >= {1'b0, den});
   assign ddiff = dsh - {1'b0, den};

   // Final values before saturation
   assign est_full  = sq_ff ? (WW'(rsel_ff) << FRAC_BITS) : WW'(dq_ff);
   assign root_full = WW'(rsel_ff);

   assign status.is_square = (rem_ff == '0);

   // Next values per microcode operation
   always_comb begin
      n_in      = n_ff;
      rad_in    = rad_ff;
      root_in   = root_ff;
      rem_in    = rem_ff;
      rsel_in   = rsel_ff;
      sq_in     = sq_ff;
      dq_in     = dq_ff;
      drem_in   = drem_ff;
      strobe_in = 1'b0;
      osq_in    = osq_ff;
      oroot_in  = oroot_ff;
      oest_in   = oest_ff;
      case (ctrl.op)
         nsse_pkg::OP_LOAD: begin
            if (ctrl.accept) begin
               n_in    = value;
               rad_in  = RADW'(value);
               root_in = '0;
               rem_in  = '0;
            end
         end
         nsse_pkg::OP_SQRT: begin
            rad_in  = rad_ff << 2;
            root_in = {root_ff[RW-2:0], sge};
            rem_in  = sge ? sdiff[RW:0] : trial[RW:0];
         end
         nsse_pkg::OP_PICK: begin
            rsel_in = go_up ? (RW+1)'(root_ff) + (RW+1)'(1) : (RW+1)'(root_ff);
            sq_in   = (rem_ff == '0);
            dq_in   = DW'(num) << FRAC_BITS;
            drem_in = '0;
         end
         nsse_pkg::OP_DIV: begin
            dq_in   = {dq_ff[DW-2:0], dge};
            drem_in = dge ? ddiff[DENW-1:0] : dsh[DENW-1:0];
         end
         nsse_pkg::OP_FINISH: begin
            strobe_in = 1'b1;
            osq_in    = sq_ff;
            oroot_in  = (|root_full[WW-1:OW_R]) ? '1 : root_full[OW_R-1:0];
            oest_in   = (|est_full[WW-1:OW_E]) ? '1 : est_full[OW_E-1:0];
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   // Payload registers
   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      rad_ff   <= rad_in;
      root_ff  <= root_in;
      rem_ff   <= rem_in;
      rsel_ff  <= rsel_in;
      sq_ff    <= sq_in;
      dq_ff    <= dq_in;
      drem_ff  <= drem_in;
      osq_ff   <= osq_in;
      oroot_ff <= oroot_in;
      oest_ff  <= oest_in;
   end

   // Result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_is_square    = osq_ff;
   assign rsp_near_root    = oroot_ff;
   assign rsp_estimate_q16 = oest_ff;

endmodule
`default_nettype wire

// File: rtl/core/nearest_square_sqrt_estimate.sv
// Top level of the nearest-square square-root estimator.
//
// Usage: drive req_value and raise start; the value is taken at the clock edge
// where start is high and busy is low. busy stays high while the item is
// worked on. One result per item appears on the rsp_ ports for exactly one
// cycle with rsp_strobe high: rsp_is_square, rsp_near_root (root of the
// nearer square, upper on a tie, saturated) and rsp_estimate_q16 (one
// Babylonian step, FRAC_BITS fraction bits, truncated, saturated).
// After the accepting edge the sequencer runs RW = (IN_WIDTH+1)/2 root steps,
// a pick step, DW = IN_WIDTH + 2 + FRAC_BITS division steps and a finish step;
// rsp_strobe is registered after the finish step. A perfect square skips the
// division. A new item can be taken in the strobe cycle, not before; the
// single shared datapath steps the root one bit-pair and the quotient one
// bit per cycle under a microcode sequencer.
// Reset returns the sequencer to idle and drops rsp_strobe.
// The receiver cannot stall: each result is a one-cycle transfer.
`default_nettype none
module nearest_square_sqrt_estimate #(
   parameter int IN_WIDTH  = nsse_pkg::IN_WIDTH_DEF,
   parameter int FRAC_BITS = nsse_pkg::FRAC_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [IN_WIDTH-1:0]          req_value,
   output logic                              rsp_strobe,
   output logic                              rsp_is_square,
   output logic [nsse_pkg::ROOT_W-1:0]       rsp_near_root,
   output logic [nsse_pkg::EST_W-1:0]        rsp_estimate_q16
);

   nsse_pkg::dp_ctrl_type   ctrl;
   nsse_pkg::dp_status_type status;

   // Sequence the microcode program
   nsse_sequencer #(
      .IN_WIDTH  (IN_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   // Execute load, root, pick, division and finish steps
   nsse_datapath #(
      .IN_WIDTH  (IN_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .value            (req_value),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_is_square    (rsp_is_square),
      .rsp_near_root    (rsp_near_root),
      .rsp_estimate_q16 (rsp_estimate_q16)
   );

endmodule
`default_nettype wire

// File: rtl/core/nsse_checker.sv
// Port-level assertions for the square-root estimator and their bind.
`default_nettype none
`include "nearest_square_sqrt_estimate_macros.svh"
module nsse_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic                         rsp_strobe,
   input wire logic                         rsp_is_square,
   input wire logic [nsse_pkg::ROOT_W-1:0]  rsp_near_root,
   input wire logic [nsse_pkg::EST_W-1:0]   rsp_estimate_q16
);

   // An accepted transfer makes the block busy
   `NSSE_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy not raised after accept")

   // A result comes only at the end of a busy period
   `NSSE_ASSERT_SAME(a_strobe_end, clock, reset, rsp_strobe, $fell(busy), "result without busy end")

   // A result lasts one cycle
   `NSSE_ASSERT_NEXT(a_strobe_pulse, clock, reset, rsp_strobe, !rsp_strobe, "result held over one cycle")

   // Zero has a zero estimate
   `NSSE_ASSERT_SAME(a_zero_est, clock, reset, rsp_strobe && rsp_is_square && (rsp_near_root == '0), rsp_estimate_q16 == '0, "nonzero estimate for zero")

endmodule

bind nearest_square_sqrt_estimate nsse_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_is_square    (rsp_is_square),
   .rsp_near_root    (rsp_near_root),
   .rsp_estimate_q16 (rsp_estimate_q16)
);
`default_nettype wire
